// ----- hw/rtl/pkbenc_pkg.sv -----
// ----------------------------------------------------------------------------
// PackBits encoder package
// Shared types, command and status structs, and constants of the encoder.
// ----------------------------------------------------------------------------
package pkbenc_pkg;

  // Default longest group, run or literal, in bytes.
  localparam int MAX_GROUP_DEF = 128;

  // Code emitted after the flush at end of stream.
  localparam logic [7:0] END_CODE = 8'd128;

  // A run header is this base minus the run length, taken modulo 256.
  localparam logic [8:0] RUN_BASE = 9'd257;

  // Input operation codes.
  localparam logic OP_DATA = 1'b0;
  localparam logic OP_END  = 1'b1;

  // Grouping mode of the encoder.
  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_RUN  = 2'd1,
    MODE_LIT  = 2'd2
  } mode_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_HDR,
    S_LIT,
    S_RUN,
    S_END
  } ctrl_state_t;

  // Source of the byte pushed into the output packer.
  typedef enum logic [2:0] {
    PUSH_LIT_HDR,
    PUSH_RUN_HDR,
    PUSH_MEM,
    PUSH_RUN_BYTE,
    PUSH_END
  } push_sel_t;

  // New value of the pending count.
  typedef enum logic [1:0] {
    CNT_CLR,
    CNT_ONE,
    CNT_INC,
    CNT_TWO
  } cnt_op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      capture;
    logic      lit_load;
    logic      lit_short;
    logic      lit_dec;
    logic      rd_en;
    logic      push;
    push_sel_t push_sel;
    logic      closing;
    logic      run_max;
    logic      upd;
    logic      wr;
    logic      wr_at_zero;
    mode_t     mode_next;
    cnt_op_t   cnt_op;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic  op;
    logic  eq;
    mode_t mode;
    logic  n_zero;
    logic  n_one;
    logic  n_full;
    logic  n_last_slot;
    logic  lit_one;
    logic  push_ready;
  } status_t;

endpackage

// ----- hw/rtl/pkbenc_ctrl.sv -----
// ----------------------------------------------------------------------------
// PackBits encoder controller
// Decides what each accepted item emits and sequences header, literal bytes,
// run byte, end code and the final state update.
// ----------------------------------------------------------------------------
module pkbenc_ctrl
  import pkbenc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t st,
  output cmd_t    cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  // Plan for the captured item; the status it depends on holds until the update.
  logic    act_run;
  logic    act_lit;
  logic    lit_emit;
  logic    run_emit;
  logic    end_emit;
  logic    lit_short;
  logic    run_max;
  logic    upd_wr;
  logic    upd_at_zero;
  mode_t   upd_mode;
  cnt_op_t upd_cnt;

  always_comb begin
    act_run     = (st.mode == MODE_RUN) && !st.n_zero;
    act_lit     = (st.mode == MODE_LIT) && !st.n_zero;
    lit_emit    = 1'b0;
    run_emit    = 1'b0;
    end_emit    = 1'b0;
    lit_short   = 1'b0;
    run_max     = 1'b0;
    upd_wr      = 1'b1;
    upd_at_zero = 1'b0;
    upd_mode    = MODE_RUN;
    upd_cnt     = CNT_INC;
    priority if (st.op == OP_END) begin
      // Flush the pending group, then the end code.
      end_emit = 1'b1;
      lit_emit = !st.n_zero && ((st.mode == MODE_LIT) || st.n_one);
      run_emit = !st.n_zero && !((st.mode == MODE_LIT) || st.n_one);
      upd_wr   = 1'b0;
      upd_mode = MODE_IDLE;
      upd_cnt  = CNT_CLR;
    end else if (act_run) begin
      if (st.eq) begin
        // The run grows; a full run is emitted at once.
        run_emit = st.n_last_slot;
        run_max  = 1'b1;
        upd_mode = st.n_last_slot ? MODE_IDLE : MODE_RUN;
        upd_cnt  = st.n_last_slot ? CNT_CLR : CNT_INC;
      end else begin
        // A run of two or more is emitted; a run of one turns into a literal.
        run_emit    = !st.n_one;
        upd_mode    = MODE_LIT;
        upd_at_zero = !st.n_one;
        upd_cnt     = st.n_one ? CNT_INC : CNT_ONE;
      end
    end else if (act_lit) begin
      if (!st.eq) begin
        // A full literal goes out before the byte is appended.
        lit_emit    = st.n_full;
        upd_mode    = st.n_full ? MODE_RUN : MODE_LIT;
        upd_at_zero = st.n_full;
        upd_cnt     = st.n_full ? CNT_ONE : CNT_INC;
      end else begin
        // The last byte and the new one start a run of two.
        lit_emit    = !st.n_one;
        lit_short   = 1'b1;
        upd_at_zero = 1'b1;
        upd_mode    = MODE_RUN;
        upd_cnt     = CNT_TWO;
      end
    end else begin
      // Nothing pending: the byte starts a run of one.
      upd_at_zero = 1'b1;
      upd_mode    = MODE_RUN;
      upd_cnt     = CNT_ONE;
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next     = state;
    in_stall       = 1'b1;
    cmd            = '0;
    cmd.push_sel   = PUSH_END;
    cmd.lit_short  = lit_short;
    cmd.run_max    = run_max;
    cmd.wr         = upd_wr;
    cmd.wr_at_zero = upd_at_zero;
    cmd.mode_next  = upd_mode;
    cmd.cnt_op     = upd_cnt;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EVAL;
        end
      end
      S_EVAL: begin
        if (lit_emit || run_emit) begin
          cmd.lit_load = lit_emit;
          state_next   = S_HDR;
        end else if (end_emit) begin
          state_next = S_END;
        end else begin
          cmd.upd    = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_HDR: begin
        cmd.push     = 1'b1;
        cmd.push_sel = lit_emit ? PUSH_LIT_HDR : PUSH_RUN_HDR;
        if (st.push_ready) begin
          cmd.rd_en  = lit_emit;
          state_next = lit_emit ? S_LIT : S_RUN;
        end
      end
      S_LIT: begin
        cmd.push     = 1'b1;
        cmd.push_sel = PUSH_MEM;
        cmd.closing  = st.lit_one && !end_emit;
        if (st.push_ready) begin
          cmd.lit_dec = 1'b1;
          if (!st.lit_one) begin
            cmd.rd_en = 1'b1;
          end else if (end_emit) begin
            state_next = S_END;
          end else begin
            cmd.upd    = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      S_RUN: begin
        cmd.push     = 1'b1;
        cmd.push_sel = PUSH_RUN_BYTE;
        cmd.closing  = !end_emit;
        if (st.push_ready) begin
          if (end_emit) begin
            state_next = S_END;
          end else begin
            cmd.upd    = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      S_END: begin
        cmd.push     = 1'b1;
        cmd.push_sel = PUSH_END;
        cmd.closing  = 1'b1;
        if (st.push_ready) begin
          cmd.upd    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/pkbenc_dp.sv -----
// ----------------------------------------------------------------------------
// PackBits encoder datapath
// Holds mode, pending count and the literal buffer, builds coded bytes and
// packs them four to a result word behind an output register.
// ----------------------------------------------------------------------------
module pkbenc_dp
  import pkbenc_pkg::*;
#(
  parameter int MAX_GROUP = MAX_GROUP_DEF
)
(
  input  logic        clk,
  input  logic        rst,
  input  logic        op,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_bytes,
  output logic [2:0]  out_count,
  output logic        out_last,
  input  cmd_t        cmd,
  output status_t     st
);

  localparam int CNT_W = $clog2(MAX_GROUP + 1);
  localparam int IDX_W = $clog2(MAX_GROUP);

  logic             in_op;
  logic [7:0]       in_byte;
  mode_t            mode;
  logic [CNT_W-1:0] cnt;
  logic [7:0]       last_byte;
  logic [CNT_W-1:0] lit_left;
  logic [IDX_W-1:0] rd_ptr;
  logic [7:0]       mem_q;
  logic [7:0]       mem [MAX_GROUP];
  logic [IDX_W-1:0] wr_addr;

  logic [2:0][7:0]  acc;
  logic [1:0]       acc_cnt;
  logic [3:0][7:0]  word;
  logic [7:0]       push_byte;
  logic [CNT_W-1:0] run_len;
  logic             out_free;
  logic             push_ok;
  logic             emit_word;

  // Status for the controller.
  assign out_free = !out_valid || !out_stall;
  always_comb begin
    st             = '0;
    st.op          = in_op;
    st.eq          = (in_byte == last_byte);
    st.mode        = mode;
    st.n_zero      = (cnt == '0);
    st.n_one       = (cnt == CNT_W'(1));
    st.n_full      = (cnt == CNT_W'(MAX_GROUP));
    st.n_last_slot = (cnt == CNT_W'(MAX_GROUP - 1));
    st.lit_one     = (lit_left == CNT_W'(1));
    st.push_ready  = out_free || (!cmd.closing && (acc_cnt != 2'd3));
  end

  // Captured input item.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_op   <= op;
      in_byte <= data_byte;
    end
  end

  // Mode, pending count and last byte change only at the end of an item.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE;
      cnt  <= '0;
    end else if (cmd.upd) begin
      mode <= cmd.mode_next;
      unique case (cmd.cnt_op)
        CNT_CLR: cnt <= '0;
        CNT_ONE: cnt <= CNT_W'(1);
        CNT_INC: cnt <= cnt + CNT_W'(1);
        CNT_TWO: cnt <= CNT_W'(2);
        default: cnt <= '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd && cmd.wr) begin
      last_byte <= in_byte;
    end
  end

  // Literal buffer: one write port at the update, one registered read port.
  // Entries of a run of two or more are never read back.
  assign wr_addr = cmd.wr_at_zero ? '0 : cnt[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.upd && cmd.wr) begin
      mem[wr_addr] <= in_byte;
    end
    if (cmd.rd_en) begin
      mem_q <= mem[rd_ptr];
    end
  end

  // Literal length and read pointer for a flush.
  always_ff @(posedge clk) begin
    if (cmd.lit_load) begin
      lit_left <= cmd.lit_short ? (cnt - CNT_W'(1)) : cnt;
      rd_ptr   <= '0;
    end else begin
      if (cmd.lit_dec) begin
        lit_left <= lit_left - CNT_W'(1);
      end
      if (cmd.rd_en) begin
        rd_ptr <= rd_ptr + IDX_W'(1);
      end
    end
  end

  // Coded byte selection.
  assign run_len = cmd.run_max ? CNT_W'(MAX_GROUP) : cnt;
  always_comb begin
    unique case (cmd.push_sel)
      PUSH_LIT_HDR:  push_byte = 8'(lit_left) - 8'd1;
      PUSH_RUN_HDR:  push_byte = 8'(RUN_BASE - 9'(run_len));
      PUSH_MEM:      push_byte = mem_q;
      PUSH_RUN_BYTE: push_byte = last_byte;
      PUSH_END:      push_byte = END_CODE;
      default:       push_byte = END_CODE;
    endcase
  end

  // Result word: held bytes, the new byte, zeros above.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (2'(j) < acc_cnt) begin
        word[j] = acc[j];
      end else if (2'(j) == acc_cnt) begin
        word[j] = push_byte;
      end else begin
        word[j] = 8'h00;
      end
    end
    word[3] = (acc_cnt == 2'd3) ? push_byte : 8'h00;
  end

  assign push_ok   = cmd.push && st.push_ready;
  assign emit_word = push_ok && (cmd.closing || (acc_cnt == 2'd3));

  // Packer: gather bytes, hand a word to the output register when four are
  // held or the item's final byte arrives.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc     <= '0;
      acc_cnt <= 2'd0;
    end else if (emit_word) begin
      acc     <= '0;
      acc_cnt <= 2'd0;
    end else if (push_ok) begin
      acc[acc_cnt] <= push_byte;
      acc_cnt      <= acc_cnt + 2'd1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_word) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_word) begin
      out_bytes <= word;
      out_count <= 3'(acc_cnt) + 3'd1;
      out_last  <= cmd.closing;
    end
  end

endmodule

// ----- hw/rtl/packbits_encoder.sv -----
// ----------------------------------------------------------------------------
// PackBits encoder
// Run-length encoder for a byte stream with end-of-stream flush and end code.
// ----------------------------------------------------------------------------
// One raw byte, or an end-of-stream marker, is taken per transfer, and the
// PackBits code comes out packed up to four bytes per result word, first byte
// in bits 7:0, with out_last on the final word that an item causes. An item
// occupies the block while its coded bytes go out, 0 for most data bytes and
// up to MAX_GROUP + 2 for a literal flush at end of stream, and also while
// out_stall holds a full result word. The packer takes one coded byte per
// cycle while no full word is held up by out_stall, and literal bytes leave
// the buffer through its single registered read port, one per cycle, on the
// same terms. The next item is taken once the item's final byte has entered
// the output register, while that word still waits to be taken.
module packbits_encoder
  import pkbenc_pkg::*;
#(
  parameter int MAX_GROUP = MAX_GROUP_DEF
)
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_bytes,
  output logic [2:0]  out_count,
  output logic        out_last
);

  cmd_t    cmd;
  status_t st;

  // Sequencing of each item.
  pkbenc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // Group state, literal buffer and output packing.
  pkbenc_dp #(
    .MAX_GROUP (MAX_GROUP)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .data_byte (data_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_bytes (out_bytes),
    .out_count (out_count),
    .out_last  (out_last),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

// ----- hw/rtl/pkbenc_checker.sv -----
// ----------------------------------------------------------------------------
// PackBits encoder port checker
// Checks result words and the handshake as seen at the top-level ports.
// ----------------------------------------------------------------------------
module pkbenc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        op,
  input logic [7:0]  data_byte,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_bytes,
  input logic [2:0]  out_count,
  input logic        out_last
);

  // A result word holds one to four bytes.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_count == 3'd1 || out_count == 3'd2 ||
                   out_count == 3'd3 || out_count == 3'd4))
    else $error("result byte count out of range");

  // Bytes above the count are zero.
  a_upper_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_count != 3'd1 || out_bytes[31:8] == 24'd0) &&
                   (out_count != 3'd2 || out_bytes[31:16] == 16'd0) &&
                   (out_count != 3'd3 || out_bytes[31:24] == 8'd0)))
    else $error("bytes above the count are not zero");

  // Only the final word of an item may be short, and while an earlier word
  // waits the item is still being coded, so no new transfer is taken.
  a_full_nonlast: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_last) |-> (out_count == 3'd4 && in_stall))
    else $error("non-final result is short or input was released early");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_bytes) &&
                                  $stable(out_count) && $stable(out_last)))
    else $error("stalled result changed");

  // A stalled input transfer holds its payload.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_stall) |=> (in_valid && $stable(op) && $stable(data_byte)))
    else $error("stalled input changed");

endmodule

bind packbits_encoder pkbenc_checker u_checker (.*);

// ----- tb/tb_packbits_encoder.sv -----
// ----------------------------------------------------------------------------
// PackBits encoder testbench
// Self-checking bench that drives byte and end-of-stream transfers into the
// encoder, predicts the packed code words in step, and checks every result
// word field by field in arrival order, under random idling and back-pressure.
// ----------------------------------------------------------------------------
module tb_packbits_encoder;
  import pkbenc_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 7;
  localparam int LONG_HOLD    = 300;
  localparam int SETTLE       = 40;
  localparam int LIMIT_CYCLES = 600000;

  // One packed result word as the encoder should deliver it.
  typedef struct {
    logic [31:0] bytes;
    logic [2:0]  count;
    logic        last;
  } coded_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        op = OP_DATA;
  logic [7:0]  data_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_bytes;
  logic [2:0]  out_count;
  logic        out_last;

  // Encoder state as the predictor sees it.
  mode_t       enc_mode = MODE_IDLE;
  int unsigned pend_cnt = 0;
  logic [7:0]  group_buf [128];
  logic [7:0]  code_buf [$];
  coded_word_t coded_words_q [$];

  // Run controls and statistics.
  bit idle_on = 1'b1;
  int hold_reqs = 0;
  int holds_done = 0;
  int err_count = 0;
  int items_sent = 0;
  int eos_sent = 0;
  int words_checked = 0;
  int max_words = 0;
  int full_runs = 0;
  int full_lits = 0;

  packbits_encoder dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .data_byte (data_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_bytes (out_bytes),
    .out_count (out_count),
    .out_last  (out_last)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // A literal group: its length minus one, then the buffered bytes.
  function automatic void emit_literal(input int unsigned n);
    int unsigned i;
    if (n == 0) return;
    if (n == MAX_GROUP_DEF) full_lits++;
    code_buf.push_back(8'(n - 1));
    for (i = 0; i < n; i++) code_buf.push_back(group_buf[i]);
  endfunction

  // A run: the header 257 minus the length, then the repeated byte.
  function automatic void emit_run(input int unsigned n, input logic [7:0] b);
    if (n == MAX_GROUP_DEF) full_runs++;
    code_buf.push_back(8'(int'(RUN_BASE) - int'(n)));
    code_buf.push_back(b);
  endfunction

  // Advances the predicted state by one accepted transfer and queues the
  // code words it causes.
  function automatic void encode_item(input logic o, input logic [7:0] b);
    int unsigned n;
    int          k;
    int          j;
    coded_word_t w;
    n = pend_cnt;
    code_buf.delete();
    if (o == OP_END) begin
      if (n > 0) begin
        if (enc_mode == MODE_LIT || n == 1) emit_literal(n);
        else emit_run(n, group_buf[n - 1]);
      end
      code_buf.push_back(END_CODE);
      enc_mode = MODE_IDLE;
      n = 0;
    end else if (enc_mode == MODE_RUN && n > 0) begin
      if (b == group_buf[n - 1]) begin
        group_buf[n] = b;
        n++;
        if (n >= MAX_GROUP_DEF) begin
          emit_run(n, b);
          n = 0;
          enc_mode = MODE_IDLE;
        end
      end else begin
        if (n > 1) begin
          emit_run(n, group_buf[n - 1]);
          n = 0;
        end
        group_buf[n] = b;
        n++;
        enc_mode = MODE_LIT;
      end
    end else if (enc_mode == MODE_LIT && n > 0) begin
      if (b != group_buf[n - 1]) begin
        // A full literal is flushed before the new byte opens the next group.
        if (n >= MAX_GROUP_DEF) begin
          emit_literal(n);
          n = 0;
          enc_mode = MODE_RUN;
        end
        group_buf[n] = b;
        n++;
      end else begin
        // The repeated byte leaves the literal and starts a run of two.
        if (n > 1) emit_literal(n - 1);
        group_buf[0] = b;
        group_buf[1] = b;
        n = 2;
        enc_mode = MODE_RUN;
      end
    end else begin
      group_buf[0] = b;
      n = 1;
      enc_mode = MODE_RUN;
    end
    pend_cnt = n;

    // Pack the coded bytes four to a word, first byte lowest.
    for (k = 0; k < code_buf.size(); k += 4) begin
      w.bytes = '0;
      w.count = '0;
      for (j = 0; j < 4 && k + j < code_buf.size(); j++) begin
        w.bytes[8 * j +: 8] = code_buf[k + j];
        w.count++;
      end
      w.last = (k + 4 >= code_buf.size());
      coded_words_q.push_back(w);
    end
    if ((code_buf.size() + 3) / 4 > max_words) max_words = (code_buf.size() + 3) / 4;
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    err_count++;
    $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  // Each result transfer is compared with the oldest predicted word.
  always @(posedge clk) begin : result_check
    coded_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (coded_words_q.size() == 0) begin
        report_mismatch($sformatf("result word %h with nothing predicted", out_bytes));
      end else begin
        want = coded_words_q.pop_front();
        words_checked++;
        if (out_bytes !== want.bytes)
          report_mismatch($sformatf("out_bytes %h, predicted %h", out_bytes, want.bytes));
        if (out_count !== want.count)
          report_mismatch($sformatf("out_count %0d, predicted %0d", out_count, want.count));
        if (out_last !== want.last)
          report_mismatch($sformatf("out_last %b, predicted %b", out_last, want.last));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall bursts, and a long hold-off on request.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int n;
    forever begin
      @(posedge clk);
      if (holds_done != hold_reqs) begin
        holds_done++;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 5);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------

  // Offers one item, with a random gap first, and returns at the edge where
  // the transfer takes place. Valid stays high for a following item.
  task automatic send_item(input logic o, input logic [7:0] b);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    op        <= o;
    data_byte <= b;
    do @(posedge clk); while (in_stall);
    encode_item(o, b);
    items_sent++;
    if (o == OP_END) eos_sent++;
  endtask

  // Stops offering and waits until every predicted word has arrived.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (coded_words_q.size() != 0);
  endtask

  task automatic send_run(input int len, input logic [7:0] b);
    repeat (len) send_item(OP_DATA, b);
  endtask

  // Bytes that differ from their neighbor, so they form a literal.
  task automatic send_literal(input int len);
    logic [7:0] prev;
    logic [7:0] b;
    prev = 8'($urandom);
    repeat (len) begin
      b = 8'($urandom);
      if (b == prev) b = ~b;
      send_item(OP_DATA, b);
      prev = b;
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Short directed cases: end of stream at idle, group of one, run of two,
  // each mode change, and the byte extremes.
  task automatic test_special_cases();
    send_item(OP_END, 8'hFF);
    send_item(OP_DATA, 8'h00);
    send_item(OP_END, 8'h00);
    send_run(2, 8'hFF);
    send_item(OP_END, 8'h5A);
    // Literal that ends in a repeat, then a run broken by another byte.
    send_item(OP_DATA, 8'h12);
    send_item(OP_DATA, 8'h34);
    send_item(OP_DATA, 8'h34);
    send_item(OP_DATA, 8'h56);
    send_item(OP_END, 8'h00);
    // Plain literal of three.
    send_item(OP_DATA, 8'hA5);
    send_item(OP_DATA, 8'h5A);
    send_item(OP_DATA, 8'hA5);
    send_item(OP_END, 8'hFF);
    // Run of three flushed by a new byte, which then becomes a run of two.
    send_run(3, 8'h80);
    send_run(2, 8'h7F);
    send_item(OP_DATA, 8'h01);
    send_item(OP_END, 8'h00);
  endtask

  // Groups at the maximum length: a full run emitted on its last byte, after
  // which end of stream finds nothing pending, and a full literal flushed by
  // the next byte, which is then flushed at end of stream.
  task automatic test_group_limits();
    send_run(MAX_GROUP_DEF, 8'hFF);
    send_item(OP_END, 8'h00);
    send_literal(MAX_GROUP_DEF + 1);
    send_item(OP_END, 8'h00);
  endtask

  // The receiver holds off for a long stretch while items that produce
  // results keep coming, so the encoder fills and stalls its input. Then the
  // sender pauses until every result is in before going on.
  task automatic test_output_hold();
    hold_reqs++;
    repeat (3) begin
      send_item(OP_DATA, 8'($urandom));
      send_item(OP_END, 8'($urandom));
    end
    wait_drained();
  endtask

  // Short well-formed runs and literals with random content, mixed with end
  // of stream, noise and pauses.
  task automatic test_random_stream(input int n_items, input bit with_idle);
    int stop_at;
    int kind;
    int len;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      idle_on = with_idle && ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 99);
      len  = $urandom_range(1, 8);
      if (kind < 40) begin
        send_run(len < 2 ? 2 : len, 8'($urandom));
      end else if (kind < 72) begin
        send_literal(len);
      end else if (kind < 84) begin
        send_item(OP_END, 8'($urandom));
      end else if (kind < 96) begin
        // Noise: random operations over a small alphabet, so repeats happen.
        repeat ($urandom_range(1, 6)) begin
          case ($urandom_range(0, 3))
            0: send_item(($urandom_range(0, 7) == 0) ? OP_END : OP_DATA, 8'h00);
            1: send_item(($urandom_range(0, 7) == 0) ? OP_END : OP_DATA, 8'hFF);
            default: send_item(($urandom_range(0, 7) == 0) ? OP_END : OP_DATA,
                               8'($urandom));
          endcase
        end
      end else begin
        wait_drained();
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin : main
    for (int i = 0; i < 128; i++) group_buf[i] = 8'h00;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_special_cases();
    test_group_limits();
    test_output_hold();
    test_random_stream(12, 1'b1);
    test_random_stream(8, 1'b0);
    send_item(OP_END, 8'h00);

    idle_on = 1'b0;
    wait_drained();
    repeat (SETTLE) @(posedge clk);

    $display("Run covered %0d transfers in, %0d of them end of stream, and %0d result words.",
             items_sent, eos_sent, words_checked);
    $display("Longest burst %0d words; %0d full runs and %0d full literals were flushed.",
             max_words, full_runs, full_lits);
    if (err_count == 0) begin
      $display("tb_packbits_encoder passed");
    end else begin
      $display("tb_packbits_encoder failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("Timeout with %0d result words outstanding.", coded_words_q.size());
    $display("tb_packbits_encoder failed");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/pkbenc_pkg.sv
hw/rtl/pkbenc_ctrl.sv
hw/rtl/pkbenc_dp.sv
hw/rtl/packbits_encoder.sv
hw/rtl/pkbenc_checker.sv
tb/tb_packbits_encoder.sv
